/* hw/rtl/ntrg_pkg.sv */
// Shared types, constants and permutation ROM for the noise table random generator.
`timescale 1ns / 1ps

package ntrg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 25;
  localparam int unsigned FracW  = 23;
  localparam int unsigned ResW   = 6;

  // Moduli for the four sub-seed bytes (byte 3 down to byte 0).
  localparam logic [ResW-1:0] MOD_B3 = 6'd47;
  localparam logic [ResW-1:0] MOD_B2 = 6'd53;
  localparam logic [ResW-1:0] MOD_B1 = 6'd59;
  localparam logic [ResW-1:0] MOD_B0 = 6'd61;

  // Per-draw decrements of the sub-seed bytes.
  localparam logic [ByteW-1:0] STEP_B0 = 8'h1C;
  localparam logic [ByteW-1:0] STEP_B1 = 8'h18;
  localparam logic [ByteW-1:0] STEP_B2 = 8'h0C;
  localparam logic [ByteW-1:0] STEP_B3 = 8'h04;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] sub;
  } seed_div_t;

  typedef struct packed {
    logic             restart;
    logic [WordW-1:0] mix;
  } mix_stage_t;

  localparam logic [ByteW-1:0] PERM_ROM [256] = '{
    8'h8E, 8'h14, 8'h27, 8'h99, 8'hFD, 8'hAA, 8'hC7, 8'h08, 8'hD5, 8'hE6, 8'h3E, 8'h1F,
    8'hF6, 8'hBB, 8'h55, 8'hDA, 8'h75, 8'hA0, 8'h4A, 8'h6A, 8'hE8, 8'hBD, 8'h97, 8'hFF,
    8'hDE, 8'h9B, 8'hBC, 8'h9F, 8'h81, 8'h8A, 8'hA1, 8'h46, 8'h6E, 8'h0B, 8'hE3, 8'h63,
    8'h76, 8'h7A, 8'h6C, 8'h5D, 8'h88, 8'hD3, 8'h69, 8'hCA, 8'hC3, 8'h47, 8'hB9, 8'h25,
    8'h83, 8'hAB, 8'hA2, 8'h3F, 8'hA6, 8'h41, 8'h7C, 8'hBA, 8'hE5, 8'hAC, 8'h95, 8'h01,
    8'h7E, 8'hCF, 8'h09, 8'hC1, 8'hD9, 8'h62, 8'h70, 8'h71, 8'h8D, 8'hDB, 8'h05, 8'h02,
    8'h24, 8'h87, 8'hEF, 8'h54, 8'hC6, 8'hD4, 8'h37, 8'h30, 8'hD0, 8'h1B, 8'hCB, 8'h7B,
    8'hB8, 8'hE4, 8'hD8, 8'hEC, 8'h49, 8'hCE, 8'hAD, 8'hDC, 8'h13, 8'hA9, 8'h94, 8'hC4,
    8'h8F, 8'h39, 8'hAE, 8'h0D, 8'h18, 8'h52, 8'hDD, 8'h0E, 8'h78, 8'hFA, 8'hF5, 8'h85,
    8'h58, 8'hD2, 8'hAF, 8'h6D, 8'hA4, 8'hB2, 8'h53, 8'h3B, 8'h51, 8'hA5, 8'h50, 8'hBE,
    8'hFC, 8'h2D, 8'hF4, 8'h11, 8'h48, 8'h98, 8'h16, 8'hF1, 8'h86, 8'hDF, 8'h3D, 8'h66,
    8'h5E, 8'h44, 8'h2E, 8'h2F, 8'h36, 8'h07, 8'h6B, 8'h17, 8'h8B, 8'h29, 8'h4C, 8'hB6,
    8'hE2, 8'h89, 8'h5F, 8'hE7, 8'hCD, 8'hA7, 8'h21, 8'hE1, 8'h4D, 8'hC9, 8'h65, 8'hED,
    8'hFE, 8'hEE, 8'h9C, 8'h23, 8'h33, 8'h7D, 8'hB7, 8'h04, 8'h9E, 8'h9A, 8'h2A, 8'h40,
    8'hB3, 8'h10, 8'h5B, 8'hF3, 8'h82, 8'h77, 8'h1C, 8'h92, 8'h20, 8'h4E, 8'h1E, 8'h57,
    8'h22, 8'h72, 8'h06, 8'h8C, 8'h67, 8'h2C, 8'h73, 8'hFB, 8'h59, 8'hC2, 8'h0A, 8'hBF,
    8'h79, 8'h5C, 8'hF9, 8'h0C, 8'h28, 8'h1A, 8'h12, 8'h68, 8'h74, 8'h34, 8'h19, 8'h42,
    8'hB1, 8'hC0, 8'h84, 8'hF8, 8'h38, 8'hF0, 8'h15, 8'h9D, 8'h60, 8'hF2, 8'h3A, 8'h6F,
    8'hB4, 8'h90, 8'hEB, 8'h91, 8'h1D, 8'h7F, 8'h35, 8'h61, 8'h5A, 8'h32, 8'h03, 8'h56,
    8'hA3, 8'hC5, 8'h2B, 8'h93, 8'h80, 8'h0F, 8'h4B, 8'h43, 8'hF7, 8'hA8, 8'hE0, 8'h3C,
    8'h96, 8'hD1, 8'h64, 8'h26, 8'hD7, 8'h45, 8'hCC, 8'h4F, 8'hC8, 8'hB0, 8'hE9, 8'hB5,
    8'h00, 8'hD6, 8'h31, 8'hEA
  };

  // Little-endian 32-bit word from four consecutive ROM bytes, address wraps at 256.
  function automatic logic [WordW-1:0] rom_word(input logic [ByteW-1:0] addr);
    logic [ByteW-1:0] a1;
    logic [ByteW-1:0] a2;
    logic [ByteW-1:0] a3;
    a1 = addr + 8'd1;
    a2 = addr + 8'd2;
    a3 = addr + 8'd3;
    return {PERM_ROM[a3], PERM_ROM[a2], PERM_ROM[a1], PERM_ROM[addr]};
  endfunction

endpackage

/* hw/rtl/ntrg_seed_div.sv */
// Constant remainder unit that folds a new seed into the packed sub-seed bytes.
`timescale 1ns / 1ps

module ntrg_seed_div import ntrg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WordW-1:0] seed_in,
  output seed_div_t        status
);

  // Folded value widths: four weighted bytes fit in 16 bits, a second fold in 14 bits.
  localparam int unsigned Fold1W     = 16;
  localparam int unsigned Fold2W     = 14;
  localparam int unsigned RecipW     = 15;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned ProdW      = Fold2W + RecipW;
  localparam int unsigned QuotW      = ProdW - RecipShift;

  logic [WordW-1:0] seed_q;
  logic [3:0]       stage_vld;
  logic             done;
  logic [WordW-1:0] sub_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
      done      <= 1'b0;
    end else begin
      stage_vld <= {stage_vld[2:0], start};
      done      <= stage_vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      seed_q <= seed_in;
    end
  end

  // One lane per sub-seed byte. The seed bytes are weighted by 2^(8k) modulo the
  // modulus, folded once more, and the remainder is taken by a reciprocal multiply
  // that is exact for every value below 2^14.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam int unsigned Modulus = (i == 3) ? int'(MOD_B3)
                                    : (i == 2) ? int'(MOD_B2)
                                    : (i == 1) ? int'(MOD_B1) : int'(MOD_B0);
    localparam logic [ResW-1:0]   ModC  = ResW'(Modulus);
    localparam logic [ResW-1:0]   W8    = ResW'(256 % Modulus);
    localparam logic [ResW-1:0]   W16   = ResW'(65536 % Modulus);
    localparam logic [ResW-1:0]   W24   = ResW'(32'h0100_0000 % Modulus);
    localparam logic [RecipW-1:0] Recip =
      RecipW'(((1 << RecipShift) + Modulus - 1) / Modulus);

    logic [Fold1W-1:0] s1;
    logic [Fold1W-1:0] s1_next;
    logic [Fold2W-1:0] s2;
    logic [Fold2W-1:0] s2_next;
    logic [Fold2W-1:0] s2_hold;
    logic [ProdW-1:0]  prod;
    logic [QuotW-1:0]  q;
    logic [Fold2W-1:0] diff;
    logic [ResW-1:0]   r;

    always_comb begin
      s1_next = Fold1W'(seed_q[7:0])
              + Fold1W'(seed_q[15:8])  * Fold1W'(W8)
              + Fold1W'(seed_q[23:16]) * Fold1W'(W16)
              + Fold1W'(seed_q[31:24]) * Fold1W'(W24);
      s2_next = Fold2W'(s1[7:0]) + Fold2W'(s1[15:8]) * Fold2W'(W8);
      prod    = ProdW'(s2) * ProdW'(Recip);
      diff    = s2_hold - Fold2W'(q) * Fold2W'(ModC);
    end

    always_ff @(posedge clk) begin
      s1      <= s1_next;
      s2      <= s2_next;
      s2_hold <= s2;
      q       <= prod[ProdW-1:RecipShift];
      r       <= diff[ResW-1:0];
    end

    assign sub_bytes[ByteW*i +: ByteW] = {r, 2'b00};
  end

  assign status.busy = (|stage_vld) | done;
  assign status.done = done;
  assign status.sub  = sub_bytes;

endmodule

/* hw/rtl/ntrg_mix_stage.sv */
// Mixing stage: four ROM word reads, fixed rotates and XOR into a registered mix word.
`timescale 1ns / 1ps

module ntrg_mix_stage import ntrg_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             restart_in,
  input  logic [WordW-1:0] bytes,
  output mix_stage_t       stage
);

  logic [WordW-1:0] w0, w1, w2, w3;
  logic [WordW-1:0] mix_next;

  always_comb begin
    w0 = rom_word(bytes[7:0]);
    w1 = rom_word(bytes[15:8]);
    w2 = rom_word(bytes[23:16]);
    w3 = rom_word(bytes[31:24]);
    // Byte 0 unrotated, byte 3 by one, byte 2 by two, byte 1 by three.
    mix_next = w0
             ^ {w3[WordW-2:0], w3[WordW-1]}
             ^ {w2[WordW-3:0], w2[WordW-1:WordW-2]}
             ^ {w1[WordW-4:0], w1[WordW-1:WordW-3]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.restart <= restart_in;
      stage.mix     <= mix_next;
    end
  end

endmodule

/* hw/rtl/noise_table_random_generator.sv */
// Top level of the seeded noise table random generator.
`timescale 1ns / 1ps

// Channel   | Signals                          | Direction | Contents
// ----------+----------------------------------+-----------+--------------------------------
// request   | in_valid, in_ready, restart      | in        | one draw, optional reseed
// result    | out_valid, out_ready, raw_word,  | out       | new accumulator and Q1.23
//           | coord_fixed                      |           | coordinate in [-1,1]
// config    | cfg_we, cfg_data                 | in        | seed register, no wait
//
// A draw passes from request to result through the sub-seed byte update, the ROM
// mix stage, then the accumulator add into the result register. One request is taken
// every cycle; each stage holds when the one after it is full and not draining.
// After reset the seed, sub-seed bytes, accumulator and valid flags are zero and a
// request is taken at once. A seed write reloads the accumulator at once, and the
// remainder unit then blocks requests while it folds the seed into the sub-seed bytes.

module noise_table_random_generator import ntrg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [WordW-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [WordW-1:0]         raw_word,
  output logic signed [CoordW-1:0] coord_fixed
);

  logic [WordW-1:0] seed;
  logic [WordW-1:0] seed_sub;     // packed sub-seed bytes of the current seed
  logic [WordW-1:0] sub_seed;     // live sub-seed bytes, also the bytes of stage A
  logic [WordW-1:0] sub_seed_next;
  logic [WordW-1:0] sub_base;
  logic [WordW-1:0] acc;
  logic [WordW-1:0] acc_next;

  logic             a_valid;
  logic             a_restart;
  logic             b_valid;
  logic             in_fire;
  logic             a_move;
  logic             b_move;
  logic             out_fire;

  seed_div_t        div_status;
  mix_stage_t       mix;

  logic [CoordW-1:0] coord_neg;

  // Remainder unit runs after every seed write.
  ntrg_seed_div u_seed_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .seed_in (cfg_data),
    .status  (div_status)
  );

  // Handshake chain through the three stages.
  always_comb begin
    out_fire = out_valid & out_ready;
    b_move   = b_valid & (~out_valid | out_ready);
    a_move   = a_valid & (~b_valid | b_move);
    in_ready = ~div_status.busy & (~a_valid | a_move);
    in_fire  = in_valid & in_ready;
  end

  // Stage A: reseed if asked, then step the four sub-seed bytes down with 8-bit wrap.
  always_comb begin
    sub_base      = restart ? seed_sub : sub_seed;
    sub_seed_next = {sub_base[31:24] - STEP_B3,
                     sub_base[23:16] - STEP_B2,
                     sub_base[15:8]  - STEP_B1,
                     sub_base[7:0]   - STEP_B0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= '0;
      seed_sub <= '0;
      sub_seed <= '0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_data;
      end
      if (div_status.done) begin
        seed_sub <= div_status.sub;
        sub_seed <= div_status.sub;
      end else if (in_fire) begin
        sub_seed <= sub_seed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_restart <= restart;
    end
  end

  // Stage B: ROM lookups and mixing of the bytes held in stage A.
  ntrg_mix_stage u_mix_stage (
    .clk        (clk),
    .load       (a_move),
    .restart_in (a_restart),
    .bytes      (sub_seed),
    .stage      (mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  // Stage C: accumulate into the result register. A restart draw starts from the seed.
  assign acc_next = (mix.restart ? seed : acc) + mix.mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cfg_we) begin
      acc <= cfg_data;
    end else if (b_move) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_move) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      raw_word <= acc_next;
    end
  end

  // The negative coordinate f - 2^23 is just f with the two top bits set; the positive
  // one, 2^23 - f, is its two's complement.
  always_comb begin
    coord_neg   = {2'b11, raw_word[FracW-1:0]};
    coord_fixed = raw_word[WordW-1] ? $signed(~coord_neg + 25'd1) : $signed(coord_neg);
  end

endmodule

/* bench/tb_noise_table_random_generator.sv */
// Self-checking testbench for the noise table random generator, with a driver and a monitor.
`timescale 1ns / 1ps

module tb_noise_table_random_generator;
  import ntrg_pkg::*;

  // One expected draw: the new accumulator and the matching Q1.23 coordinate.
  typedef struct packed {
    logic [WordW-1:0]         raw;
    logic signed [CoordW-1:0] coord;
  } draw_t;

  // Cycles without any transfer before the run is declared hung. The slowest correct
  // stretch is the long result hold-off or a seed reload, far below this.
  localparam int unsigned HangLimit = 2000;
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned PipeDrain = 6;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [WordW-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     restart = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [WordW-1:0]         raw_word;
  logic signed [CoordW-1:0] coord_fixed;

  // Requests waiting to be offered; each entry is the restart flag of one draw.
  logic  pending_draws[$];
  // Draw results predicted at request acceptance, oldest first.
  draw_t expected_draws[$];

  // Our own copy of the generator state and the seed register.
  logic [WordW-1:0] gen_seed;
  logic [WordW-1:0] gen_acc;
  logic [WordW-1:0] gen_sub;

  // Idle rates in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // A toggle of hold_go asks the receiver for one long hold-off.
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  noise_table_random_generator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .raw_word   (raw_word),
    .coord_fixed(coord_fixed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Appends one request to the end of the pending list.
  function automatic void add_pending(input logic reseed);
    pending_draws = {pending_draws, reseed};
  endfunction

  // The seed register loads the accumulator directly and the sub-seed bytes from the
  // seed's remainders modulo 47, 53, 59 and 61, placed at bits 26, 18, 10 and 2.
  function automatic void reload_from_seed();
    logic [WordW-1:0] r3, r2, r1, r0;
    r3 = gen_seed % 32'd47;
    r2 = gen_seed % 32'd53;
    r1 = gen_seed % 32'd59;
    r0 = gen_seed % 32'd61;
    gen_acc = gen_seed;
    gen_sub = (r3 << 26) | (r2 << 18) | (r1 << 10) | (r0 << 2);
  endfunction

  // Four ROM bytes from addr upward, little-endian, with the address wrapping at 256.
  function automatic logic [WordW-1:0] perm_word(input logic [ByteW-1:0] addr);
    logic [WordW-1:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w[8*k +: 8] = PERM_ROM[8'(addr + 8'(k))];
    end
    return w;
  endfunction

  function automatic logic [WordW-1:0] rotate_left(input logic [WordW-1:0] v, input int n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction

  // One draw: step the sub-seed bytes down with byte wrap, mix four rotated ROM words
  // into the accumulator and derive the coordinate 1-f, signed by accumulator bit 31.
  function automatic draw_t advance_generator(input logic reseed);
    logic [ByteW-1:0]         b0, b1, b2, b3;
    logic [WordW-1:0]         mix;
    logic signed [CoordW-1:0] mag;
    draw_t                    d;
    if (reseed) reload_from_seed();
    b0 = gen_sub[7:0] - STEP_B0;
    b1 = gen_sub[15:8] - STEP_B1;
    b2 = gen_sub[23:16] - STEP_B2;
    b3 = gen_sub[31:24] - STEP_B3;
    gen_sub = {b3, b2, b1, b0};
    mix = perm_word(b0) ^ rotate_left(perm_word(b3), 1)
        ^ rotate_left(perm_word(b2), 2) ^ rotate_left(perm_word(b1), 3);
    gen_acc = gen_acc + mix;
    mag = 25'sh0800000 - CoordW'({2'b00, gen_acc[FracW-1:0]});
    d.raw = gen_acc;
    d.coord = gen_acc[WordW-1] ? mag : -mag;
    return d;
  endfunction

  // Driver. The prediction is made at the edge where a request is accepted, so the
  // expected queue always follows the order in which the block takes requests. A
  // held request stays on the port unchanged until in_ready takes it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gen_seed = '0;
      reload_from_seed();
    end else begin
      if (cfg_we) begin
        gen_seed = cfg_data;
        reload_from_seed();
      end
      if (in_valid && in_ready) begin
        expected_draws = {expected_draws, advance_generator(restart)};
      end
      if (!in_valid || in_ready) begin
        if (pending_draws.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          restart  <= pending_draws.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side flow control. A toggle of hold_go starts a long hold-off
  // counted here; otherwise out_ready follows the phase's idle rate.
  always @(posedge clk) begin
    draw_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result raw_word=%h coord_fixed=%0d",
                   $time, raw_word, coord_fixed);
        end else begin
          want = expected_draws.pop_front();
          if (raw_word !== want.raw) begin
            mismatches++;
            $display("%0t: raw_word expected %h actual %h", $time, want.raw, raw_word);
          end
          if (coord_fixed !== want.coord) begin
            mismatches++;
            $display("%0t: coord_fixed expected %0d actual %0d",
                     $time, want.coord, coord_fixed);
          end
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen <= hold_go;
        hold_left <= HoldCycles;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any transfer on any port restarts the count.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until no request is pending or in flight, then let the pipeline settle so
  // that a seed write sees an idle block.
  task automatic wait_idle();
    while (pending_draws.size() != 0 || in_valid || expected_draws.size() != 0) begin
      @(posedge clk);
    end
    repeat (PipeDrain) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WordW-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly long free-running runs, with an occasional reseed from the register.
  task automatic queue_random_draws(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      add_pending($urandom_range(15) == 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: straight from reset with seed zero, whose sub-seed bytes all wrap on
    // the first draw, then restarts back to back and in between free-running draws.
    for (int k = 0; k < 6; k++) add_pending(1'b0);
    add_pending(1'b1);
    add_pending(1'b1);
    add_pending(1'b0);
    add_pending(1'b0);
    wait_idle();

    // Largest seed, restart on the very first request after the reload.
    write_seed(32'hFFFF_FFFF);
    add_pending(1'b1);
    for (int k = 0; k < 5; k++) add_pending(1'b0);
    add_pending(1'b1);
    for (int k = 0; k < 4; k++) add_pending(1'b0);
    wait_idle();

    // Smallest seed written explicitly, and a seed with only the top bit set.
    write_seed(32'h0000_0000);
    add_pending(1'b0);
    add_pending(1'b1);
    wait_idle();
    write_seed(32'h8000_0000);
    add_pending(1'b0);
    add_pending(1'b0);
    add_pending(1'b1);
    wait_idle();

    // Random phase one: a slow sender against a slower receiver. The drain at the
    // end of each phase is also the sender's pause until every result is back.
    send_idle_pct <= 36;
    recv_idle_pct <= 70;
    write_seed($urandom);
    queue_random_draws(120);
    wait_idle();
    write_seed($urandom);
    queue_random_draws(120);
    wait_idle();

    // Random phase two: the roles swapped.
    send_idle_pct <= 70;
    recv_idle_pct <= 36;
    write_seed($urandom);
    queue_random_draws(120);
    wait_idle();
    write_seed($urandom);
    queue_random_draws(120);
    wait_idle();

    // Random phase three: no idling, plus one long result hold-off while the sender
    // keeps offering, so the pipeline fills and in_ready drops.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_seed($urandom);
    queue_random_draws(240);
    repeat (20) @(posedge clk);
    hold_go <= ~hold_go;
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ntrg_pkg.sv
hw/rtl/ntrg_seed_div.sv
hw/rtl/ntrg_mix_stage.sv
hw/rtl/noise_table_random_generator.sv
bench/tb_noise_table_random_generator.sv
